// ===== design/tbbs_pkg.sv =====
// shared types and constants of the table block binning sum block
package tbbs_pkg;

  localparam int ACC_W  = 48;
  localparam int SUM_W  = 56;
  localparam int PROD_W = 88;
  localparam int DIV_W  = 40;
  localparam int BINS   = 8;
  localparam int DCNT_W = 7;

  typedef enum logic [2:0] {
    REG_SCALE     = 3'd0,
    REG_AVERAGE   = 3'd1,
    REG_COLUMNS   = 3'd2,
    REG_COL_CUTS  = 3'd3,
    REG_COL_BINS  = 3'd4,
    REG_ROW_LOW   = 3'd5,
    REG_ROW_HIGH  = 3'd6,
    REG_ROW_BINS  = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic cap_cell;
    logic acc_write;
    logic row_init;
    logic col_init;
    logic sum_rd;
    logic sum_add;
    logic scale_init;
    logic mul_lo;
    logic mul_hi;
    logic mul_sum;
    logic div_step;
    logic fin;
    logic emit;
    logic row_end;
  } cmd_t;

  typedef struct packed {
    logic active;
    logic row_done;
    logic bin_ready;
    logic cbins_zero;
    logic col_has_cells;
    logic sum_last;
    logic rwidth_zero;
    logic div_last;
    logic out_free;
    logic col_last;
  } sts_t;

endpackage

// ===== design/tbbs_ram.sv =====
// generic single write port ram with registered read
module tbbs_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 255,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/tbbs_ctrl.sv =====
// controller state machine of the table block binning sum block
module tbbs_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  tbbs_pkg::sts_t sts,
  output tbbs_pkg::cmd_t cmd
);

  import tbbs_pkg::*;

  typedef enum logic [13:0] {
    S_IDLE      = 14'b00000000000001,
    S_ACC_WR    = 14'b00000000000010,
    S_ROW_CHK   = 14'b00000000000100,
    S_COL_START = 14'b00000000001000,
    S_SUM_RD    = 14'b00000000010000,
    S_SUM_ADD   = 14'b00000000100000,
    S_SCALE     = 14'b00000001000000,
    S_MUL_LO    = 14'b00000010000000,
    S_MUL_HI    = 14'b00000100000000,
    S_MUL_SUM   = 14'b00001000000000,
    S_DIV       = 14'b00010000000000,
    S_FIN       = 14'b00100000000000,
    S_EMIT      = 14'b01000000000000,
    S_ROW_END   = 14'b10000000000000
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid && sts.active) begin
          cmd.cap_cell = 1'b1;
          state_nxt = S_ACC_WR;
        end
      end
      S_ACC_WR: begin
        cmd.acc_write = 1'b1;
        state_nxt = sts.row_done ? S_ROW_CHK : S_IDLE;
      end
      S_ROW_CHK: begin
        if (sts.bin_ready) begin
          cmd.row_init = 1'b1;
          state_nxt = sts.cbins_zero ? S_ROW_END : S_COL_START;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_COL_START: begin
        cmd.col_init = 1'b1;
        state_nxt = sts.col_has_cells ? S_SUM_RD : S_SCALE;
      end
      S_SUM_RD: begin
        cmd.sum_rd = 1'b1;
        state_nxt = S_SUM_ADD;
      end
      S_SUM_ADD: begin
        cmd.sum_add = 1'b1;
        state_nxt = sts.sum_last ? S_SCALE : S_SUM_RD;
      end
      S_SCALE: begin
        cmd.scale_init = 1'b1;
        state_nxt = sts.rwidth_zero ? S_EMIT : S_MUL_LO;
      end
      S_MUL_LO: begin
        cmd.mul_lo = 1'b1;
        state_nxt = S_MUL_HI;
      end
      S_MUL_HI: begin
        cmd.mul_hi = 1'b1;
        state_nxt = S_MUL_SUM;
      end
      S_MUL_SUM: begin
        cmd.mul_sum = 1'b1;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        cmd.fin = 1'b1;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          state_nxt = sts.col_last ? S_ROW_END : S_COL_START;
        end
      end
      S_ROW_END: begin
        cmd.row_end = 1'b1;
        state_nxt = S_ROW_CHK;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== design/tbbs_dp.sv =====
// datapath of the table block binning sum block: registers, accumulators, scaler, divider
module tbbs_dp #(
  parameter int MAX_COLUMNS = 255
) (
  input  logic                clk,
  input  logic                rst_n,
  input  tbbs_pkg::cmd_t      cmd,
  output tbbs_pkg::sts_t      sts,
  input  logic signed [31:0]  in_cell_value,
  input  logic                cfg_valid,
  input  logic [2:0]          cfg_index,
  input  logic [63:0]         cfg_data,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [63:0]  out_bin_value,
  output logic [2:0]          out_row_bin_index,
  output logic [2:0]          out_column_bin_index,
  output logic                out_end_of_row
);

  import tbbs_pkg::*;

  localparam int AW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;

  logic [31:0] scale_r;
  logic        avg_r;
  logic [7:0]  col_count_r;
  logic [63:0] col_cuts_r;
  logic [3:0]  col_bins_r;
  logic [63:0] row_lo_r;
  logic [63:0] row_hi_r;
  logic [3:0]  row_bins_r;

  logic [31:0]        cell_r;
  logic [7:0]         col_pos_r;
  logic [15:0]        row_cnt_r;
  logic [3:0]         rbp_r;
  logic [15:0]        rstart_r;
  logic [15:0]        cut_r;
  logic [15:0]        rwidth_r;
  logic [3:0]         cbin_r;
  logic [7:0]         wpos_r;
  logic [7:0]         cwidth_r;
  logic [SUM_W-1:0]   sum_r;
  logic               neg_r;
  logic [SUM_W-1:0]   amag_r;
  logic [31:0]        smag_r;
  logic [DIV_W-1:0]   d_r;
  logic [63:0]        plo_r;
  logic [SUM_W-1:0]   phi_r;
  logic [PROD_W-1:0]  dvd_r;
  logic [DIV_W-1:0]   rem_r;
  logic [DCNT_W-1:0]  dcnt_r;
  logic [63:0]        result_r;
  logic               rd_vld_r;
  logic [MAX_COLUMNS-1:0] valid_r;
  logic               out_valid_r;

  logic [7:0]        ncols;
  logic [3:0]        rbins;
  logic [3:0]        cbins;
  logic [7:0]        pos_eff;
  logic [127:0]      row_cuts;
  logic [15:0]       cut_w;
  logic [15:0]       rwidth_w;
  logic [7:0]        cc_raw;
  logic [7:0]        cc;
  logic [AW-1:0]     rd_addr;
  logic [AW-1:0]     wr_addr;
  logic [ACC_W-1:0]  rd_data;
  logic [ACC_W-1:0]  acc_old;
  logic [ACC_W-1:0]  acc_new;
  logic [23:0]       area;
  logic [DIV_W:0]    r2;
  logic              ge;
  logic              rnd;
  logic [PROD_W:0]   qr;
  logic [PROD_W:0]   max_pos;

  always_comb begin
    if (col_count_r == 8'd0) begin
      ncols = 8'd1;
    end else if (int'(col_count_r) > MAX_COLUMNS) begin
      ncols = 8'(MAX_COLUMNS);
    end else begin
      ncols = col_count_r;
    end
    rbins    = (row_bins_r > 4'(BINS)) ? 4'(BINS) : row_bins_r;
    cbins    = (col_bins_r > 4'(BINS)) ? 4'(BINS) : col_bins_r;
    pos_eff  = (col_pos_r >= ncols) ? 8'd0 : col_pos_r;
    row_cuts = {row_hi_r, row_lo_r};
    cut_w    = row_cuts[{rbp_r[2:0], 4'b0000} +: 16];
    rwidth_w = (cut_w > rstart_r) ? 16'(cut_w - rstart_r) : 16'd0;
    cc_raw   = col_cuts_r[{cbin_r[2:0], 3'b000} +: 8];
    cc       = (cc_raw > ncols) ? ncols : cc_raw;
    rd_addr  = cmd.sum_rd ? AW'(wpos_r) : AW'(pos_eff);
    wr_addr  = AW'(col_pos_r);
    acc_old  = rd_vld_r ? rd_data : '0;
    acc_new  = acc_old + ACC_W'({{(ACC_W-32){cell_r[31]}}, cell_r});
    area     = 24'(rwidth_r) * 24'(cwidth_r);
    r2       = {rem_r, dvd_r[PROD_W-1]};
    ge       = (r2 >= {1'b0, d_r});
    rnd      = (rem_r >= DIV_W'(d_r - rem_r));
    qr       = {1'b0, dvd_r} + (PROD_W+1)'(rnd);
    max_pos  = (PROD_W+1)'(64'h7FFF_FFFF_FFFF_FFFF);
  end

  tbbs_ram #(.WIDTH(ACC_W), .DEPTH(MAX_COLUMNS)) u_acc_ram (
    .clk   (clk),
    .we    (cmd.acc_write),
    .waddr (wr_addr),
    .wdata (acc_new),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  always_comb begin
    sts.active        = (rbp_r < rbins);
    sts.row_done      = ({1'b0, col_pos_r} + 9'd1 >= {1'b0, ncols});
    sts.bin_ready     = (rbp_r < rbins) && (cut_w <= row_cnt_r);
    sts.cbins_zero    = (cbins == 4'd0);
    sts.col_has_cells = (cc > wpos_r);
    sts.sum_last      = ({1'b0, wpos_r} + 9'd1 >= {1'b0, cc});
    sts.rwidth_zero   = (rwidth_r == 16'd0);
    sts.div_last      = (dcnt_r == DCNT_W'(PROD_W - 1));
    sts.out_free      = !out_valid_r || out_ready;
    sts.col_last      = (cbin_r + 4'd1 >= cbins);
  end

  // configuration and control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r     <= 32'h0001_0000;
      avg_r       <= 1'b0;
      col_count_r <= 8'd255;
      col_cuts_r  <= '1;
      col_bins_r  <= 4'd1;
      row_lo_r    <= '1;
      row_hi_r    <= '1;
      row_bins_r  <= 4'd1;
      col_pos_r   <= '0;
      row_cnt_r   <= '0;
      rbp_r       <= '0;
      rstart_r    <= '0;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (reg_idx_t'(cfg_index))
          REG_SCALE:    scale_r     <= cfg_data[31:0];
          REG_AVERAGE:  avg_r       <= cfg_data[0];
          REG_COLUMNS:  col_count_r <= cfg_data[7:0];
          REG_COL_CUTS: col_cuts_r  <= cfg_data;
          REG_COL_BINS: col_bins_r  <= cfg_data[3:0];
          REG_ROW_LOW:  row_lo_r    <= cfg_data;
          REG_ROW_HIGH: row_hi_r    <= cfg_data;
          REG_ROW_BINS: row_bins_r  <= cfg_data[3:0];
          default: ;
        endcase
      end
      if (cmd.cap_cell) begin
        col_pos_r <= pos_eff;
      end
      if (cmd.acc_write) begin
        valid_r[wr_addr] <= 1'b1;
        if (sts.row_done) begin
          col_pos_r <= '0;
          if (row_cnt_r != 16'hFFFF) begin
            row_cnt_r <= row_cnt_r + 16'd1;
          end
        end else begin
          col_pos_r <= col_pos_r + 8'd1;
        end
      end
      if (cmd.row_end) begin
        if (rwidth_r != 16'd0) begin
          valid_r  <= '0;
          rstart_r <= cut_r;
        end
        rbp_r <= rbp_r + 4'd1;
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // bin walk, scaler and divider payload
  always_ff @(posedge clk) begin
    rd_vld_r <= valid_r[rd_addr];
    if (cmd.cap_cell) begin
      cell_r <= in_cell_value;
    end
    if (cmd.row_init) begin
      cut_r    <= cut_w;
      rwidth_r <= rwidth_w;
      cbin_r   <= '0;
      wpos_r   <= '0;
    end
    if (cmd.col_init) begin
      sum_r    <= '0;
      cwidth_r <= (cc > wpos_r) ? 8'(cc - wpos_r) : 8'd0;
    end
    if (cmd.sum_add) begin
      sum_r  <= sum_r + SUM_W'({{(SUM_W-ACC_W){acc_old[ACC_W-1]}}, acc_old});
      wpos_r <= wpos_r + 8'd1;
    end
    if (cmd.scale_init) begin
      neg_r    <= sum_r[SUM_W-1] ^ scale_r[31];
      amag_r   <= sum_r[SUM_W-1] ? SUM_W'(~sum_r + 1'b1) : sum_r;
      smag_r   <= scale_r[31] ? 32'(~scale_r + 1'b1) : scale_r;
      d_r      <= (avg_r && area != 24'd0) ? {area, 16'h0000} : DIV_W'(65536);
      result_r <= '0;
    end
    if (cmd.mul_lo) begin
      plo_r <= 64'(amag_r[31:0]) * 64'(smag_r);
    end
    if (cmd.mul_hi) begin
      phi_r <= SUM_W'(amag_r[SUM_W-1:32]) * SUM_W'(smag_r);
    end
    if (cmd.mul_sum) begin
      dvd_r  <= PROD_W'(plo_r) + {phi_r, 32'h0000_0000};
      rem_r  <= '0;
      dcnt_r <= '0;
    end
    if (cmd.div_step) begin
      rem_r  <= ge ? DIV_W'(r2 - {1'b0, d_r}) : r2[DIV_W-1:0];
      dvd_r  <= {dvd_r[PROD_W-2:0], ge};
      dcnt_r <= dcnt_r + 1'b1;
    end
    if (cmd.fin) begin
      if (!neg_r) begin
        result_r <= (qr > max_pos) ? 64'h7FFF_FFFF_FFFF_FFFF : qr[63:0];
      end else begin
        result_r <= (qr > max_pos + 1'b1) ? 64'h8000_0000_0000_0000 : (~qr[63:0] + 64'd1);
      end
    end
    if (cmd.emit) begin
      out_bin_value        <= result_r;
      out_row_bin_index    <= rbp_r[2:0];
      out_column_bin_index <= cbin_r[2:0];
      out_end_of_row       <= sts.col_last;
      cbin_r               <= cbin_r + 4'd1;
    end
  end

  assign out_valid = out_valid_r;

`ifndef SYNTHESIS
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (!out_valid_r || out_ready))
    else $error("result loaded over an untaken word");
  a_cap_active: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.cap_cell |=> cmd.acc_write)
    else $error("captured cell not written back");
  a_wr_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.acc_write |-> (col_pos_r < ncols))
    else $error("accumulator write past column count");
  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_step |-> (d_r != '0))
    else $error("divider running with zero divisor");
`endif

endmodule

// ===== design/table_block_binning_sum.sv =====
// an accepted cell reads its accumulator, then adds and writes it back
// a completed row bin stalls input while each column bin is walked: its columns are
// summed, then scaled and passed through the bit serial divider, plus output waits
// a new cell is taken only after the previous one is written back, never during a walk
// reset: synchronous active low, restores register defaults, clears positions and all
// accumulator valid bits at once so accumulators read as zero, no clearing pass
module table_block_binning_sum #(
  parameter int MAX_COLUMNS = 255
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] in_cell_value,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [63:0]        cfg_data,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [63:0] out_bin_value,
  output logic [2:0]         out_row_bin_index,
  output logic [2:0]         out_column_bin_index,
  output logic               out_end_of_row
);

  import tbbs_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  tbbs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  tbbs_dp #(.MAX_COLUMNS(MAX_COLUMNS)) u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .sts                  (sts),
    .in_cell_value        (in_cell_value),
    .cfg_valid            (cfg_valid),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_bin_value        (out_bin_value),
    .out_row_bin_index    (out_row_bin_index),
    .out_column_bin_index (out_column_bin_index),
    .out_end_of_row       (out_end_of_row)
  );

endmodule

// ===== tb/table_block_binning_sum_test.sv =====
// self-checking testbench for the table block binning sum block
module table_block_binning_sum_test;
  timeunit 1ns;
  timeprecision 1ps;

  import tbbs_pkg::*;

  localparam int NCOL_MAX   = 255;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int SETTLE      = 3000;

  typedef struct {
    logic signed [63:0] bin_value;
    logic [2:0]         row_bin;
    logic [2:0]         col_bin;
    logic               eor;
  } bin_word_t;

  typedef struct {
    logic signed [31:0] din;
    bit                 known;
    logic signed [63:0] value;
  } cell_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [31:0] in_cell_value = '0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [63:0] cfg_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [63:0] out_bin_value;
  logic [2:0] out_row_bin_index;
  logic [2:0] out_column_bin_index;
  logic out_end_of_row;

  table_block_binning_sum dut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // mirror of the block
  logic [31:0] m_scale = 32'd65536;
  logic        m_average = 1'b0;
  logic [7:0]  m_columns = 8'd255;
  logic [63:0] m_col_cuts = '1;
  logic [3:0]  m_col_bins = 4'd1;
  logic [63:0] m_row_low = '1;
  logic [63:0] m_row_high = '1;
  logic [3:0]  m_row_bins = 4'd1;
  logic [47:0] col_acc [NCOL_MAX] = '{default: '0};
  int unsigned col_pos = 0;
  int unsigned rows_seen = 0;
  int unsigned row_bin_pos = 0;
  int unsigned row_bin_first = 0;

  bin_word_t   bins_due[$];
  cell_row_t   typed_due[$];
  int          errors = 0;
  int          cycles = 0;

  function automatic int unsigned cols_eff();
    int unsigned n = m_columns;
    if (n == 0) n = 1;
    if (n > NCOL_MAX) n = NCOL_MAX;
    return n;
  endfunction

  function automatic int unsigned bins_eff(logic [3:0] v);
    return (v > BINS) ? BINS : v;
  endfunction

  function automatic int unsigned row_cut_at(int unsigned r);
    logic [63:0] w = (r < 4) ? m_row_low : m_row_high;
    return 32'((w >> (16 * (r % 4))) & 64'hFFFF);
  endfunction

  function automatic logic signed [63:0] scaled_bin(longint sum, longint unsigned area);
    logic [127:0] mag, smag, prod, div, quo, rem;
    logic signed [63:0] sc;
    bit neg;
    sc = $signed(m_scale);
    mag = (sum < 0) ? -sum : sum;
    smag = (sc < 0) ? -sc : sc;
    neg = (sum < 0) != (sc < 0);
    prod = mag * smag;
    div = (m_average && area > 0) ? (128'(area) << 16) : 128'd65536;
    quo = prod / div;
    rem = prod % div;
    if (rem >= div - rem) quo++;
    if (!neg) return (quo > 128'h7FFFFFFFFFFFFFFF) ? 64'h7FFFFFFFFFFFFFFF : quo[63:0];
    if (quo > 128'h8000000000000000) return 64'h8000000000000000;
    return -quo[63:0];
  endfunction

  function automatic int bin_cells(logic signed [31:0] cell_in);
    int unsigned n, rb, cb, cut, rw, pos, cc, cw;
    longint sum;
    bin_word_t w;
    int made = 0;
    n = cols_eff();
    rb = bins_eff(m_row_bins);
    cb = bins_eff(m_col_bins);
    if (row_bin_pos >= rb) return 0;
    if (col_pos >= n) col_pos = 0;
    col_acc[col_pos] = col_acc[col_pos] + 48'($signed(cell_in));
    col_pos++;
    if (col_pos < n) return 0;
    col_pos = 0;
    if (rows_seen < 65535) rows_seen++;
    while (row_bin_pos < rb) begin
      cut = row_cut_at(row_bin_pos);
      if (cut > rows_seen) break;
      rw = (cut > row_bin_first) ? cut - row_bin_first : 0;
      pos = 0;
      for (int c = 0; c < cb; c++) begin
        cc = 32'((m_col_cuts >> (8 * c)) & 64'hFF);
        if (cc > n) cc = n;
        sum = 0;
        cw = 0;
        if (cc > pos) begin
          cw = cc - pos;
          for (; pos < cc; pos++) sum += longint'($signed(col_acc[pos]));
        end
        w.bin_value = rw ? scaled_bin(sum, longint'(rw) * cw) : '0;
        w.row_bin = row_bin_pos[2:0];
        w.col_bin = c[2:0];
        w.eor = (c + 1 == cb);
        bins_due.push_back(w);
        made++;
      end
      if (rw) begin
        foreach (col_acc[i]) col_acc[i] = '0;
        row_bin_first = cut;
      end
      row_bin_pos++;
    end
    return made;
  endfunction

  // idling of both sides, with a calm stretch
  function automatic bit idle_now();
    if (cycles % 60000 < 12000) return 1'b0;
    return $urandom_range(99) < 26;
  endfunction

  always @(posedge clk) begin
    bin_word_t exp_w;
    cell_row_t typed;
    int made;
    cycles <= cycles + 1;
    out_ready <= !idle_now();
    if (rst_n && cfg_valid && cfg_ready) begin
      case (reg_idx_t'(cfg_index))
        REG_SCALE:    m_scale    <= cfg_data[31:0];
        REG_AVERAGE:  m_average  <= cfg_data[0];
        REG_COLUMNS:  m_columns  <= cfg_data[7:0];
        REG_COL_CUTS: m_col_cuts <= cfg_data;
        REG_COL_BINS: m_col_bins <= cfg_data[3:0];
        REG_ROW_LOW:  m_row_low  <= cfg_data;
        REG_ROW_HIGH: m_row_high <= cfg_data;
        REG_ROW_BINS: m_row_bins <= cfg_data[3:0];
        default: ;
      endcase
    end
    if (rst_n && out_valid && out_ready) begin
      if (bins_due.size() == 0) begin
        $error("unexpected word: bin_value %0d", out_bin_value);
        errors++;
      end else begin
        exp_w = bins_due.pop_front();
        if (out_bin_value !== exp_w.bin_value) begin
          $error("bin_value expected %0d actual %0d", exp_w.bin_value, out_bin_value);
          errors++;
        end
        if (out_row_bin_index !== exp_w.row_bin) begin
          $error("row_bin_index expected %0d actual %0d", exp_w.row_bin, out_row_bin_index);
          errors++;
        end
        if (out_column_bin_index !== exp_w.col_bin) begin
          $error("column_bin_index expected %0d actual %0d", exp_w.col_bin,
                 out_column_bin_index);
          errors++;
        end
        if (out_end_of_row !== exp_w.eor) begin
          $error("end_of_row expected %0d actual %0d", exp_w.eor, out_end_of_row);
          errors++;
        end
      end
    end
    if (rst_n && in_valid && in_ready) begin
      typed = typed_due.pop_front();
      made = bin_cells(in_cell_value);
      if (typed.known && made > 0 &&
          bins_due[bins_due.size() - made].bin_value !== typed.value) begin
        $error("bin_value expected %0d actual %0d", typed.value,
               bins_due[bins_due.size() - made].bin_value);
        errors++;
      end
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("table_block_binning_sum test failed");
      $finish;
    end
  end

  task automatic send_cell(logic signed [31:0] cell_in, bit known, logic signed [63:0] value);
    cell_row_t r;
    r.din = cell_in;
    r.known = known;
    r.value = value;
    if (idle_now()) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    typed_due.push_back(r);
    in_valid <= 1'b1;
    in_cell_value <= cell_in;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [63:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (bins_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic logic signed [31:0] any_cell();
    case ($urandom_range(7))
      0: return 32'sh7FFFFFFF;
      1: return 32'sh80000000;
      2: return $urandom_range(0, 262144) - 131072;
      default: return $urandom();
    endcase
  endfunction

  // random table phase: opens up to k new row bins, cut at or past the rows already seen
  task automatic table_phase(logic [31:0] scale, bit avg, logic [7:0] cols, logic [3:0] cbins,
                             int unsigned k, logic [3:0] rbins_word);
    logic [63:0] ccuts, rlow, rhigh;
    int unsigned n, cut, rows, need;
    n = (cols == 0) ? 1 : cols;
    for (int c = 0; c < 8; c++) ccuts[8*c +: 8] = 8'($urandom_range(0, n + 1));
    if ($urandom_range(1)) ccuts[7:0] = 8'(n);
    rlow = '1;
    rhigh = '1;
    cut = rows_seen;
    for (int r = row_bin_pos; r < row_bin_pos + k && r < BINS; r++) begin
      cut += (n > 16) ? $urandom_range(0, 1) : $urandom_range(0, 3);
      if (r < 4) rlow[16*r +: 16] = 16'(cut);
      else rhigh[16*(r-4) +: 16] = 16'(cut);
    end
    write_reg(REG_SCALE, {32'($urandom()), scale});
    write_reg(REG_AVERAGE, {63'($urandom()), avg});
    write_reg(REG_COLUMNS, 64'(cols));
    write_reg(REG_COL_CUTS, ccuts);
    write_reg(REG_COL_BINS, 64'(cbins));
    write_reg(REG_ROW_LOW, rlow);
    write_reg(REG_ROW_HIGH, rhigh);
    write_reg(REG_ROW_BINS, 64'(rbins_word));
    @(posedge clk);
    rows = (cut > rows_seen) ? cut - rows_seen : 1;
    need = rows * n - ((col_pos >= n) ? 0 : col_pos);
    for (int i = 0; i < need; i++) send_cell(any_cell(), 0, '0);
    settle();
  endtask

  cell_row_t opening[] = '{
    '{32'sh7FFFFFFF, 0, 0}, '{32'sh80000000, 1, 64'sh7FFFFFFF},
    '{32'shFFFFFFFF, 0, 0}, '{32'sh00000001, 1, -64'sd1},
    '{32'sh00010000, 0, 0}, '{32'sh00000000, 1, 64'sh10000}
  };

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // two columns split in two bins, rows 1 / 1 (empty) / 2 / 3
    write_reg(REG_COLUMNS, 64'd2);
    write_reg(REG_COL_CUTS, 64'h0000_0000_0000_0201);
    write_reg(REG_COL_BINS, 64'd2);
    write_reg(REG_ROW_LOW, 64'h0003_0002_0001_0001);
    write_reg(REG_ROW_BINS, 64'd4);
    @(posedge clk);
    foreach (opening[i]) send_cell(opening[i].din, opening[i].known, opening[i].value);
    settle();

    table_phase(32'h7FFFFFFF, 1'b1, 8'($urandom_range(1, 5)), 4'($urandom_range(1, 8)),
                1, 4'(row_bin_pos + 1));
    table_phase(32'h80000000, 1'b0, 8'($urandom_range(1, 5)), 4'd8, 1, 4'(row_bin_pos + 1));
    table_phase(32'd65536, 1'b1, 8'd255, 4'd8, 1, 4'(row_bin_pos + 1));
    table_phase(32'($urandom()), 1'b0, 8'd3, 4'd0, 1, 4'(row_bin_pos + 1));
    // row bins switched off: everything ignored
    write_reg(REG_ROW_BINS, 64'd0);
    @(posedge clk);
    repeat (12) send_cell(any_cell(), 0, '0);
    settle();
    table_phase(32'd0, 1'($urandom_range(1)), 8'd0, 4'd12, BINS, 4'd15);
    repeat (10) send_cell(any_cell(), 0, '0);

    in_valid <= 1'b0;
    while (bins_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (errors == 0 && bins_due.size() == 0) begin
      $display("table_block_binning_sum test passed");
    end else begin
      $display("table_block_binning_sum test failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/tbbs_pkg.sv
design/tbbs_ram.sv
design/tbbs_ctrl.sv
design/tbbs_dp.sv
design/table_block_binning_sum.sv
tb/table_block_binning_sum_test.sv
